### rtl/mtw_pkg.sv
// ----------------------------------------------------------------------------
// MT19937 word generator package
// Shared constants, request codes, queue entry type and the tempering and
// twist functions of the word generator.
// ----------------------------------------------------------------------------
package mtw_pkg;

   localparam int STATE_DEPTH = 624;
   localparam int MID_OFFSET  = 397;
   localparam int BACK_STEP   = STATE_DEPTH - MID_OFFSET;
   localparam int ADDR_W      = $clog2(STATE_DEPTH);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] SEED_MULT    = 32'd1812433253;
   localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
   localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
   localparam logic [31:0] TEMPER_C     = 32'hefc60000;
   localparam logic [31:0] TOP_BIT      = 32'h80000000;
   localparam logic [31:0] LOW_BITS     = 32'h7fffffff;
   localparam logic [31:0] SEED_RESET   = 32'd5489;

   typedef enum logic {
      OP_DRAW,
      OP_SEED_DRAW
   } mtw_op_type;

   typedef struct packed {
      logic       valid;
      mtw_op_type op;
   } mtw_entry_type;

   function automatic logic [31:0] mtw_temper(input logic [31:0] w);
      logic [31:0] t;
      t = w ^ (w >> 11);
      t = t ^ ((t << 7) & TEMPER_B);
      t = t ^ ((t << 15) & TEMPER_C);
      t = t ^ (t >> 18);
      return t;
   endfunction

   function automatic logic [31:0] mtw_twist(input logic [31:0] cur,
                                             input logic [31:0] nxt,
                                             input logic [31:0] mid);
      logic [31:0] mix;
      logic [31:0] res;
      mix = (cur & TOP_BIT) | (nxt & LOW_BITS);
      res = mid ^ (mix >> 1);
      if (mix[0]) begin
         res = res ^ TWIST_MATRIX;
      end
      return res;
   endfunction

endpackage

### rtl/mt19937_word_generator.sv
// ----------------------------------------------------------------------------
// MT19937 word generator
// Mersenne Twister returning one tempered 32-bit word per request, with
// optional reseed from the seed register.
// ----------------------------------------------------------------------------
// Plain draws are taken one per cycle; each result passes the request queue,
// the twist stage and the output register. The twist of one state word per
// draw reads the 624-word state memory at two addresses and writes one, so
// the pipeline keeps that rate for as long as results are taken. A request
// with reseed set, and the first request after reset, first waits for draws
// still in flight to drain, then refills the state from the seed register
// one word per cycle through the seed multiplier before its own draw is
// issued. Writing the seed register takes effect at the next seeding only.
module mt19937_word_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_reseed,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_value,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   logic [31:0]            seed_ff;
   logic [31:0]            seed_in;
   mtw_pkg::mtw_entry_type push;
   mtw_pkg::mtw_entry_type head;
   logic                   queue_full;
   logic                   pop;

   assign seed_in = csr_we ? csr_wdata : seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= mtw_pkg::SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   mtw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_reseed (req_reseed),
      .queue_full (queue_full),
      .push       (push)
   );

   mtw_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   mtw_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .seed      (seed_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_value (rsp_value)
   );

endmodule

### rtl/mtw_front.sv
// ----------------------------------------------------------------------------
// MT19937 request front end
// Accepts requests and classifies each one as a plain draw or as a draw that
// first reseeds the state; the first request after reset always reseeds.
// ----------------------------------------------------------------------------
module mtw_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_reseed,
   input  logic                   queue_full,
   output mtw_pkg::mtw_entry_type push
);

   logic seeded_ff;
   logic seeded_in;
   logic accept;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign push.valid = accept;
   assign push.op    = (req_reseed || !seeded_ff) ? mtw_pkg::OP_SEED_DRAW
                                                  : mtw_pkg::OP_DRAW;

   assign seeded_in = seeded_ff || accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         seeded_ff <= 1'b0;
      end else begin
         seeded_ff <= seeded_in;
      end
   end

endmodule

### rtl/mtw_queue.sv
// ----------------------------------------------------------------------------
// MT19937 request queue
// Short queue of classified requests between the front end and the
// generator back end.
// ----------------------------------------------------------------------------
module mtw_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  mtw_pkg::mtw_entry_type push,
   output logic                   full,
   output mtw_pkg::mtw_entry_type head,
   input  logic                   pop
);

   mtw_pkg::mtw_op_type             entry_ff [mtw_pkg::QUEUE_DEPTH];
   logic [mtw_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [mtw_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [mtw_pkg::QCNT_W-1:0]      count_ff, count_in;
   logic                            do_push;
   logic                            do_pop;

   function automatic logic [mtw_pkg::QPTR_W-1:0] bump(
      input logic [mtw_pkg::QPTR_W-1:0] p);
      if (p == mtw_pkg::QPTR_W'(mtw_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign full       = (count_ff == mtw_pkg::QCNT_W'(mtw_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.op    = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.op;
      end
   end

endmodule

### rtl/mtw_back.sv
// ----------------------------------------------------------------------------
// MT19937 generator back end
// Holds the state memory, fills it from the seed one word per cycle, and
// twists and tempers one state word per draw through a two-stage pipeline.
// ----------------------------------------------------------------------------
module mtw_back (
   input  logic                   clock,
   input  logic                   reset,
   input  mtw_pkg::mtw_entry_type head,
   output logic                   pop,
   input  logic [31:0]            seed,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [31:0]            rsp_value
);

   typedef enum logic {
      ST_RUN,
      ST_SEED
   } state_type;

   localparam int AW = mtw_pkg::ADDR_W;

   state_type       state_ff, state_in;
   logic [AW-1:0]   pos_ff, pos_in;
   logic [AW-1:0]   sidx_ff, sidx_in;
   logic            seed_done_ff, seed_done_in;
   logic            b_vld_ff, b_vld_in;
   logic [AW-1:0]   b_addr_ff, b_addr_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [31:0]     rsp_value_ff, rsp_value_in;
   logic [31:0]     cur_ff, cur_in;
   logic [31:0]     prev_ff, prev_in;

   logic [31:0]     mem [mtw_pkg::STATE_DEPTH];
   logic [31:0]     rd_next_ff;
   logic [31:0]     rd_mid_ff;

   logic            out_free;
   logic            b_adv;
   logic            a_fire;
   logic            seed_start;
   logic [AW-1:0]   addr_next;
   logic [AW-1:0]   addr_mid;
   logic [31:0]     seed_mixed;
   logic [31:0]     seed_prod;
   logic [31:0]     seed_word;
   logic [31:0]     twisted;
   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   logic [31:0]     mem_wdata;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign b_adv      = b_vld_ff && out_free;
   assign a_fire     = (state_ff == ST_RUN) && head.valid && (!b_vld_ff || b_adv)
                       && (head.op == mtw_pkg::OP_DRAW || seed_done_ff);
   assign seed_start = (state_ff == ST_RUN) && head.valid && !b_vld_ff
                       && (head.op == mtw_pkg::OP_SEED_DRAW) && !seed_done_ff;
   assign pop        = a_fire;

   assign addr_next = (pos_ff == AW'(mtw_pkg::STATE_DEPTH - 1)) ? '0 : pos_ff + 1'b1;
   assign addr_mid  = (pos_ff >= AW'(mtw_pkg::BACK_STEP)) ?
                      pos_ff - AW'(mtw_pkg::BACK_STEP) :
                      pos_ff + AW'(mtw_pkg::MID_OFFSET);

   assign seed_mixed = prev_ff ^ (prev_ff >> 30);
   assign seed_prod  = seed_mixed * mtw_pkg::SEED_MULT;
   assign seed_word  = (sidx_ff == '0) ? prev_ff : seed_prod + 32'(sidx_ff);

   assign twisted = mtw_pkg::mtw_twist(cur_ff, rd_next_ff, rd_mid_ff);

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = b_addr_ff;
      mem_wdata = twisted;
      if (state_ff == ST_SEED) begin
         mem_we    = 1'b1;
         mem_waddr = sidx_ff;
         mem_wdata = seed_word;
      end else if (b_adv) begin
         mem_we = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      sidx_in      = sidx_ff;
      seed_done_in = seed_done_ff;
      prev_in      = prev_ff;
      cur_in       = cur_ff;
      b_addr_in    = b_addr_ff;
      b_vld_in     = a_fire ? 1'b1 : (b_adv ? 1'b0 : b_vld_ff);
      rsp_valid_in = out_free ? b_adv : rsp_valid_ff;
      rsp_value_in = b_adv ? mtw_pkg::mtw_temper(twisted) : rsp_value_ff;
      if (b_adv) begin
         cur_in = rd_next_ff;
      end
      unique case (state_ff)
         ST_RUN: begin
            if (seed_start) begin
               state_in = ST_SEED;
               sidx_in  = '0;
               prev_in  = seed;
               cur_in   = seed;
            end else if (a_fire) begin
               seed_done_in = 1'b0;
               b_addr_in    = pos_ff;
               pos_in       = addr_next;
            end
         end
         ST_SEED: begin
            prev_in = seed_word;
            sidx_in = sidx_ff + 1'b1;
            if (sidx_ff == AW'(mtw_pkg::STATE_DEPTH - 1)) begin
               state_in     = ST_RUN;
               seed_done_in = 1'b1;
               pos_in       = '0;
               sidx_in      = '0;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         pos_ff       <= '0;
         sidx_ff      <= '0;
         seed_done_ff <= 1'b0;
         b_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         sidx_ff      <= sidx_in;
         seed_done_ff <= seed_done_in;
         b_vld_ff     <= b_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      b_addr_ff    <= b_addr_in;
      rsp_value_ff <= rsp_value_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
   end

   always_ff @(posedge clock) begin
      if (a_fire) begin
         rd_next_ff <= mem[addr_next];
         rd_mid_ff  <= mem[addr_mid];
      end
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   a_seed_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEED) |-> !b_vld_ff && !a_fire)
      else $error("seeding overlaps a draw in flight");

   a_seed_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEED && sidx_ff == AW'(mtw_pkg::STATE_DEPTH - 1))
      |=> (state_ff == ST_RUN) && seed_done_ff && (pos_ff == '0))
      else $error("seeding did not hand over at draw position zero");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (b_vld_ff && !b_adv) |=> b_vld_ff && $stable(b_addr_ff))
      else $error("stalled twist stage lost its draw");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      a_fire |-> (pos_ff < AW'(mtw_pkg::STATE_DEPTH))
                 && (addr_mid < AW'(mtw_pkg::STATE_DEPTH)))
      else $error("draw position out of range");

endmodule
